/* rtl/sliding_window_median_cost_macros.svh */
// assertion helpers for the checker of the median cost block
`ifndef SLIDING_WINDOW_MEDIAN_COST_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_COST_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SWMC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SWMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/swmc_pkg.sv */
package swmc_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int SUM_W          = 43;
	localparam int COST_W         = 42;
	localparam int WS_W           = 11;
	localparam int WINDOW_MAX_DEF = 1024;
	localparam logic [WS_W-1:0] WS_RESET = WS_W'(1);

	typedef enum logic [1:0] {
		CH_NOP,
		CH_INS,
		CH_DEL,
		CH_CLR
	} chain_op_t;

	typedef struct packed {
		chain_op_t                   op;
		logic signed [SAMPLE_W-1:0]  key;
	} chain_cmd_t;

endpackage

/* rtl/sliding_window_median_cost.sv */
// sliding window median cost
// in channel: sample and start_new under in_valid/in_ready. out channel: cost
// (sum of |s - median| over the window) and window_median under
// out_valid/out_ready. cfg_we/cfg_wdata set window_size; write it only while
// the block is idle.
// samples are kept in a ring memory in arrival order and in two sorted cell
// chains: the lower half (largest first, its front is the median) and the
// upper half (smallest first). each item goes through the accept state, a
// ring read and a chain delete per sample dropped, an insert, and a finish
// step plus one more step per half-to-half move. only one item is in work
// at a time: a new sample is taken only once the last one is through.
// while the window fills, no item goes out. a smaller window_size adds a
// ring read and a chain delete per extra drop plus one step per move that
// rebalances the halves. the ring read port and the chain shift are why a
// drop is split into a read and a delete.
// reset empties both chains and sets window_size to 1; no clearing pass.
// a stalled receiver holds the result register; the next item is still
// taken and worked on, and it waits at its last step until the register is
// free.
module sliding_window_median_cost #(
	parameter int WINDOW_MAX = swmc_pkg::WINDOW_MAX_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [swmc_pkg::WS_W-1:0]             cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [swmc_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  start_new,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [swmc_pkg::COST_W-1:0]           cost,
	output logic signed [swmc_pkg::SAMPLE_W-1:0]  window_median
);
	import swmc_pkg::*;

	localparam int HALF  = (WINDOW_MAX + 1) / 2 + 1;
	localparam int HCW   = $clog2(HALF + 1);
	localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int CT_W0 = (CNT_W > HCW) ? CNT_W : HCW;
	localparam int CT_W  = ((CT_W0 > WS_W) ? CT_W0 : WS_W) + 1;
	localparam int AD_W  = CT_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHK,
		S_DROP,
		S_BAL
	} state_t;

	state_t                     state_q;
	logic [WS_W-1:0]            ws_q;
	logic [PTR_W-1:0]           ptr_q;
	logic signed [SUM_W-1:0]    diff_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       out_valid_q;
	logic [COST_W-1:0]          cost_q;
	logic signed [SAMPLE_W-1:0] median_q;

	chain_cmd_t                 lcmd, ucmd;
	logic signed [SAMPLE_W-1:0] lfront, ufront, rdata_s;
	logic [HCW-1:0]             lcnt, ucnt;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic                       ram_we, ram_re;
	logic [PTR_W-1:0]           ram_raddr, ptr_nxt;

	logic [CT_W-1:0]            fill, eff, target, lcnt_x, ws_x;
	logic [AD_W-1:0]            old_d, old_a;
	logic                       drop_need, ins_lower, del_lower, l_over, l_under, emit;
	logic                       out_free, out_load;
	logic signed [SUM_W-1:0]    sx, rx, lf_x, uf_x, cost_sum;

	swmc_chain #(.DEPTH(HALF)) u_lower (
		.clk     (clk),
		.arst_n  (arst_n),
		.descend (1'b1),
		.cmd     (lcmd),
		.front   (lfront),
		.count   (lcnt)
	);

	swmc_chain #(.DEPTH(HALF)) u_upper (
		.clk     (clk),
		.arst_n  (arst_n),
		.descend (1'b0),
		.cmd     (ucmd),
		.front   (ufront),
		.count   (ucnt)
	);

	swmc_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX), .AW(PTR_W)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (sample_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		rdata_s = $signed(ram_rdata);
		sx      = {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
		rx      = {{(SUM_W-SAMPLE_W){rdata_s[SAMPLE_W-1]}}, rdata_s};
		lf_x    = {{(SUM_W-SAMPLE_W){lfront[SAMPLE_W-1]}}, lfront};
		uf_x    = {{(SUM_W-SAMPLE_W){ufront[SAMPLE_W-1]}}, ufront};

		fill   = CT_W'(lcnt) + CT_W'(ucnt);
		lcnt_x = CT_W'(lcnt);
		target = CT_W'((fill + CT_W'(1)) >> 1);
		ws_x   = CT_W'(ws_q);
		if (ws_q == '0) begin
			eff = CT_W'(1);
		end else if (ws_x > CT_W'(WINDOW_MAX)) begin
			eff = CT_W'(WINDOW_MAX);
		end else begin
			eff = ws_x;
		end

		drop_need = fill >= eff;
		emit      = fill == eff;
		l_over    = lcnt_x > target;
		l_under   = lcnt_x < target;

		// oldest slot sits fill places behind the write pointer
		old_d = AD_W'(ptr_q) - AD_W'(fill);
		old_a = old_d[AD_W-1] ? old_d + AD_W'(WINDOW_MAX) : old_d;
		ram_raddr = old_a[PTR_W-1:0];
		ptr_nxt   = (ptr_q == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_q + PTR_W'(1);

		if (lcnt == '0) begin
			ins_lower = !((ucnt != '0) && (sample_q > ufront));
		end else begin
			ins_lower = sample_q <= lfront;
		end
		// a value equal to the lower front is always found in the lower half
		del_lower = (lcnt != '0) && (rdata_s <= lfront);

		cost_sum = diff_q + (fill[0] ? lf_x : SUM_W'(0));
		out_free = !out_valid_q || out_ready;
		out_load = (state_q == S_BAL) && !l_over && !l_under && emit && out_free;
	end

	always_comb begin
		lcmd   = '{op: CH_NOP, key: sample_q};
		ucmd   = '{op: CH_NOP, key: sample_q};
		ram_we = 1'b0;
		ram_re = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && start_new) begin
					lcmd.op = CH_CLR;
					ucmd.op = CH_CLR;
				end
			end
			S_CHK: begin
				if (drop_need) begin
					ram_re = 1'b1;
				end else begin
					ram_we = 1'b1;
					if (ins_lower) begin
						lcmd.op = CH_INS;
					end else begin
						ucmd.op = CH_INS;
					end
				end
			end
			S_DROP: begin
				if (del_lower) begin
					lcmd = '{op: CH_DEL, key: rdata_s};
				end else begin
					ucmd = '{op: CH_DEL, key: rdata_s};
				end
			end
			S_BAL: begin
				if (l_over) begin
					lcmd = '{op: CH_DEL, key: lfront};
					ucmd = '{op: CH_INS, key: lfront};
				end else if (l_under) begin
					ucmd = '{op: CH_DEL, key: ufront};
					lcmd = '{op: CH_INS, key: ufront};
				end
			end
			default: ;
		endcase
	end

	// diff_q tracks upper-half sum minus lower-half sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ws_q        <= WS_RESET;
			ptr_q       <= '0;
			diff_q      <= '0;
			sample_q    <= '0;
			out_valid_q <= 1'b0;
			cost_q      <= '0;
			median_q    <= '0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sample_q <= sample;
						if (start_new) begin
							ptr_q  <= '0;
							diff_q <= '0;
						end
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (drop_need) begin
						state_q <= S_DROP;
					end else begin
						ptr_q   <= ptr_nxt;
						diff_q  <= ins_lower ? diff_q - sx : diff_q + sx;
						state_q <= S_BAL;
					end
				end
				S_DROP: begin
					diff_q  <= del_lower ? diff_q + rx : diff_q - rx;
					state_q <= S_CHK;
				end
				S_BAL: begin
					if (l_over) begin
						diff_q <= diff_q + {lf_x[SUM_W-2:0], 1'b0};
					end else if (l_under) begin
						diff_q <= diff_q - {uf_x[SUM_W-2:0], 1'b0};
					end else if (!emit) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						cost_q   <= cost_sum[COST_W-1:0];
						median_q <= lfront;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready      = state_q == S_IDLE;
	assign out_valid     = out_valid_q;
	assign cost          = cost_q;
	assign window_median = median_q;

endmodule

/* rtl/swmc_ram.sv */
module swmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/swmc_cell.sv */
module swmc_cell (
	input  logic                                  clk,
	input  logic                                  descend,
	input  swmc_pkg::chain_cmd_t                  cmd,
	input  logic                                  occ,
	input  logic                                  left_stays,
	input  logic signed [swmc_pkg::SAMPLE_W-1:0]  left_val,
	input  logic signed [swmc_pkg::SAMPLE_W-1:0]  right_val,
	output logic signed [swmc_pkg::SAMPLE_W-1:0]  val,
	output logic                                  stays
);
	import swmc_pkg::*;

	logic signed [SAMPLE_W-1:0] val_q;
	logic lt, eq, ahead, ahead_eq;

	// ahead: strictly earlier in chain order than the key
	always_comb begin
		lt       = val_q < $signed(cmd.key);
		eq       = val_q == $signed(cmd.key);
		ahead    = descend ? !(lt || eq) : lt;
		ahead_eq = descend ? !lt : (lt || eq);
		stays    = occ && ahead_eq;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CH_INS: begin
				// cells past the insert point shift one place back
				if (!stays) begin
					if (left_stays) begin
						val_q <= cmd.key;
					end else begin
						val_q <= left_val;
					end
				end
			end
			CH_DEL: begin
				// from the first match on, pull the neighbor forward
				if (!ahead) begin
					val_q <= right_val;
				end
			end
			default: ;
		endcase
	end

	assign val = val_q;

endmodule

/* rtl/swmc_chain.sv */
module swmc_chain #(
	parameter int DEPTH = 513
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  descend,
	input  swmc_pkg::chain_cmd_t                  cmd,
	output logic signed [swmc_pkg::SAMPLE_W-1:0]  front,
	output logic [$clog2(DEPTH+1)-1:0]            count
);
	import swmc_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]              count_q;
	logic signed [SAMPLE_W-1:0] val   [DEPTH];
	logic                       stays [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [SAMPLE_W-1:0] lv, rv;
		logic ls;

		if (i == 0) begin : g_first
			assign lv = cmd.key;
			assign ls = 1'b1;
		end else begin : g_mid
			assign lv = val[i-1];
			assign ls = stays[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rv = val[i];
		end else begin : g_inner
			assign rv = val[i+1];
		end

		swmc_cell u_cell (
			.clk        (clk),
			.descend    (descend),
			.cmd        (cmd),
			.occ        (count_q > CW'(i)),
			.left_stays (ls),
			.left_val   (lv),
			.right_val  (rv),
			.val        (val[i]),
			.stays      (stays[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				CH_INS:  count_q <= count_q + CW'(1);
				CH_DEL:  count_q <= count_q - CW'(1);
				CH_CLR:  count_q <= '0;
				default: ;
			endcase
		end
	end

	assign front = val[0];
	assign count = count_q;

endmodule

/* rtl/swmc_checker.sv */
`include "sliding_window_median_cost_macros.svh"

module swmc_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  cfg_we,
	input logic [swmc_pkg::WS_W-1:0]             cfg_wdata,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [swmc_pkg::COST_W-1:0]           cost,
	input logic signed [swmc_pkg::SAMPLE_W-1:0]  window_median
);
	import swmc_pkg::*;

	logic [WS_W-1:0] ws_q;

	// shadow of the window size register as seen on the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WS_RESET;
		end else if (cfg_we) begin
			ws_q <= cfg_wdata;
		end
	end

	`SWMC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while one is in work")
	`SWMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cost) && $stable(window_median), "stalled result changed")
	`SWMC_ASSERT_NOW(a_out_after_work, $rose(out_valid), in_ready && $past(!in_ready), "result appeared without an item in work")
	`SWMC_ASSERT_NOW(a_unit_window, out_valid && (ws_q == '0 || ws_q == WS_RESET), cost == '0, "single-sample window gave nonzero cost")

endmodule

bind sliding_window_median_cost swmc_checker u_swmc_checker (.*);
